// ===== rtl/hodec_pkg.sv =====
// Package for the hex / octal-escape text decoder.
// Holds the word types, the decoder state type and the character codes.
// No dependencies.
package hodec_pkg;

  // Character codes the decoder looks for
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_X         = 8'h78;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_THREE     = 8'h33;
  localparam logic [7:0] CHAR_SEVEN     = 8'h37;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F   = 8'h46;

  // Decoding mode
  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_HEX   = 2'd1,
    MODE_PLAIN = 2'd2,
    MODE_ESC   = 2'd3
  } mode_t;

  // Decoder state carried from one character to the next
  typedef struct packed {
    mode_t      mode;
    logic       lead_bs;
    logic [1:0] pending;
    logic [7:0] partial;
    logic       err;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    mode:    MODE_START,
    lead_bs: 1'b0,
    pending: 2'd0,
    partial: 8'd0,
    err:     1'b0
  };

  // Input word: one character of the encoded string
  typedef struct packed {
    logic [7:0] text_char;
    logic       is_last;
  } in_word_t;

  // Output word: one decoded result
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       end_of_string;
    logic       bad_encoding;
  } out_word_t;

endpackage

// ===== rtl/hodec_step.sv =====
// Combinational decode of one character against the current decoder state.
// Produces the next state and, when due, one output word.
// Depends on hodec_pkg.
module hodec_step (
  input  hodec_pkg::dec_state_t st,
  input  hodec_pkg::in_word_t   in_word,
  output hodec_pkg::dec_state_t st_next,
  output logic                  emit,
  output hodec_pkg::out_word_t  out_word
);
  import hodec_pkg::*;

  logic [7:0] c;
  logic       last;
  logic [3:0] hex_d;
  logic       hex_ok;
  logic       is_octal;
  logic       is_oct_lead;
  logic [1:0] pd;
  logic [7:0] oct_val;
  logic       got;
  logic [7:0] byte_val;
  dec_state_t nxt;

  assign c    = in_word.text_char;
  assign last = in_word.is_last;

  // Digit classification
  always_comb begin
    hex_ok = 1'b1;
    hex_d  = c[3:0];
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      hex_d = c[3:0];
    end else if ((c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) ||
                 (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)) begin
      hex_d = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign is_octal    = (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
  assign is_oct_lead = (c >= CHAR_ZERO) && (c <= CHAR_THREE);
  assign oct_val     = {st.partial[4:0], c[2:0]};

  // Octal digit count as seen by the escape logic; a count of three reads as none.
  always_comb begin
    if (st.mode == MODE_START || st.pending == 2'd3) begin
      pd = 2'd0;
    end else begin
      pd = st.pending;
    end
  end

  // Next state and decoded byte
  always_comb begin
    nxt      = st;
    got      = 1'b0;
    byte_val = 8'd0;
    if (!st.err) begin
      case (st.mode)
        MODE_START: begin
          if (st.lead_bs && c == CHAR_X) begin
            nxt.lead_bs = 1'b0;
            nxt.mode    = MODE_HEX;
            nxt.pending = 2'd0;
          end else if (st.lead_bs) begin
            // Escape sequence opening the string
            nxt.lead_bs = 1'b0;
            nxt.pending = 2'd0;
            if (c == CHAR_BACKSLASH) begin
              nxt.mode = MODE_PLAIN;
              byte_val = c;
              got      = 1'b1;
            end else if (is_oct_lead) begin
              nxt.mode    = MODE_ESC;
              nxt.partial = {5'd0, c[2:0]};
              nxt.pending = 2'd1;
            end else begin
              nxt.err = 1'b1;
            end
          end else if (c == CHAR_BACKSLASH) begin
            nxt.lead_bs = 1'b1;
          end else begin
            nxt.mode = MODE_PLAIN;
            byte_val = c;
            got      = 1'b1;
          end
        end
        MODE_HEX: begin
          if (st.pending == 2'd0) begin
            if (c == CHAR_SPACE) begin
              nxt = st;
            end else if (!hex_ok) begin
              nxt.err = 1'b1;
            end else begin
              nxt.partial = {4'd0, hex_d};
              nxt.pending = 2'd1;
            end
          end else if (!hex_ok) begin
            nxt.err = 1'b1;
          end else begin
            byte_val    = {st.partial[3:0], hex_d};
            nxt.pending = 2'd0;
            got         = 1'b1;
          end
        end
        MODE_PLAIN: begin
          if (c == CHAR_BACKSLASH) begin
            nxt.mode    = MODE_ESC;
            nxt.pending = 2'd0;
          end else begin
            byte_val = c;
            got      = 1'b1;
          end
        end
        MODE_ESC: begin
          if (pd == 2'd0) begin
            if (c == CHAR_BACKSLASH) begin
              nxt.mode = MODE_PLAIN;
              byte_val = c;
              got      = 1'b1;
            end else if (is_oct_lead) begin
              nxt.partial = {5'd0, c[2:0]};
              nxt.pending = 2'd1;
            end else begin
              nxt.err = 1'b1;
            end
          end else if (!is_octal) begin
            nxt.err = 1'b1;
          end else if (pd == 2'd1) begin
            nxt.partial = oct_val;
            nxt.pending = 2'd2;
          end else begin
            nxt.partial = oct_val;
            nxt.pending = 2'd0;
            nxt.mode    = MODE_PLAIN;
            byte_val    = oct_val;
            got         = 1'b1;
          end
        end
        default: begin
          nxt = st;
        end
      endcase
    end

    // A string that stops inside a sequence is malformed
    if (last && !nxt.err) begin
      if ((nxt.mode == MODE_START && nxt.lead_bs) ||
          (nxt.mode == MODE_HEX && nxt.pending != 2'd0) ||
          (nxt.mode == MODE_ESC)) begin
        nxt.err = 1'b1;
      end
    end
  end

  // Output word, and return to the start after the last character
  always_comb begin
    emit                   = got || last;
    out_word.data_byte     = got ? byte_val : 8'd0;
    out_word.has_data      = got;
    out_word.end_of_string = last;
    out_word.bad_encoding  = last && nxt.err;
    st_next                = last ? STATE_RESET : nxt;
  end

endmodule

// ===== rtl/hodec_out_buf.sv =====
// Output register with a skid stage for the decoder's result words.
// Lets the decoder keep taking words while a result waits downstream.
// Depends on hodec_pkg.
module hodec_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  hodec_pkg::out_word_t push_data,
  output logic                 buf_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hodec_pkg::out_word_t out_data
);
  import hodec_pkg::*;

  logic      skid_valid;
  out_word_t skid_data;
  logic      out_take;

  assign out_take  = out_valid && out_ready;
  assign buf_ready = !skid_valid;

  // Control: output register fills from the skid first, then from a new push
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  // The skid stage only holds a word behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with no output word");

  // A push is never offered while the skid stage is full.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("push while skid stage full");

  // A stalled output word leaves the skid stage untouched unless it was empty.
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_valid && !out_ready) |=> (skid_valid && $stable(skid_data)))
    else $error("skid word lost while output stalled");

endmodule

// ===== rtl/hex_or_octal_escape_decoder.sv =====
// Hex / octal-escape text decoder. Takes one character word per cycle, while
// in_ready is high, with a last-character flag and gives zero or one result word
// per character: a decoded byte, the end marker on the last character, or both.
// A string opening with backslash and 'x' is read as hex digit pairs, spaces
// allowed between pairs; any other string passes plain characters, turns a
// doubled backslash into one and three octal digits after a backslash into one
// byte. Malformed or truncated sequences raise an error reported on the end word.
// Throughput is one character per clock while the output is not stalled, set by
// the single decode step between the input register and the result register.
// Decoder state returns to the string start after each last character.
module hex_or_octal_escape_decoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hodec_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hodec_pkg::out_word_t out_data
);
  import hodec_pkg::*;

  logic       stage_valid;
  in_word_t   stage_data;
  logic       buf_ready;
  logic       stage_advance;
  dec_state_t st;
  dec_state_t st_next;
  logic       emit;
  out_word_t  result;

  assign stage_advance = stage_valid && buf_ready;
  assign in_ready      = !stage_valid || buf_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_data <= in_data;
    end
  end

  // Decoder state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (stage_advance) begin
      st <= st_next;
    end
  end

  // Decode step
  hodec_step u_step (
    .st      (st),
    .in_word (stage_data),
    .st_next (st_next),
    .emit    (emit),
    .out_word(result)
  );

  // Result register and skid stage
  hodec_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (stage_advance && emit),
    .push_data(result),
    .buf_ready(buf_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // The error flag only ever travels on the end word.
  a_err_on_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.bad_encoding) |-> out_data.end_of_string)
    else $error("error flag on a word that is not the end word");

  // A word with no byte exists only to carry the end marker.
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.has_data) |-> (out_data.end_of_string && out_data.data_byte == 8'd0))
    else $error("result word with neither byte nor end marker");

  // The last character of a string puts the decoder back at the start.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (stage_advance && stage_data.is_last) |=>
      (st.mode == MODE_START && !st.lead_bs && !st.err && st.pending == 2'd0))
    else $error("decoder not back at string start after last character");

  // Once an error is seen, no byte is produced until the string ends.
  a_err_silent: assert property (@(posedge clk) disable iff (rst)
    (stage_advance && st.err) |-> !(emit && result.has_data))
    else $error("byte decoded after an error");

endmodule
